@@ rtl/kpl_pkg.sv @@
package kpl_pkg;

    // keypad grid and entry sizes
    localparam int ROWS         = 4;
    localparam int COLUMNS      = 4;
    localparam int MAX_PIN_KEYS = 8;
    localparam int NUM_KEYS     = 16;
    localparam int SLOTS        = 8;

    // led codes as they appear on the result
    typedef enum logic [1:0] {
        LED_OFF    = 2'd0,
        LED_GREEN  = 2'd1,
        LED_RED    = 2'd2,
        LED_YELLOW = 2'd3
    } t_led;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PIN_LENGTH = 2'd0,
        REG_PIN_CODE   = 2'd1,
        REG_TIMEOUT    = 2'd2
    } t_reg_idx;

    // key store command from the sequencer
    typedef struct packed {
        logic       wr_en;
        logic [2:0] slot;
        logic [3:0] key;
    } t_entry_cmd;

    // key position lies inside the populated grid
    function automatic logic key_in_grid(input logic [3:0] key);
        return (int'(key[3:2]) < ROWS) && (int'(key[1:0]) < COLUMNS);
    endfunction

    // pin length clamped to the supported range
    function automatic logic [3:0] eff_len(input logic [3:0] len);
        logic [3:0] res;
        res = len;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (int'(len) > MAX_PIN_KEYS) begin
            res = 4'(MAX_PIN_KEYS);
        end
        return res;
    endfunction

endpackage

@@ rtl/keypad_pin_entry_lock.sv @@
// Keypad PIN entry lock.
// Input stream: one transaction per full keypad scan. s_axis_tdata carries the
// pressed mask (bit row*4+column), s_axis_tuser the one-second tick flag.
// Output stream: one transaction per scan with the LED color, the accepted and
// rejected entry counts, the timeout flag and the keys held in the open entry.
// An APB port holds pin_length (0x0), pin_code (0x4) and timeout_seconds (0x8);
// write it only while no scan is in flight.
// The sequencer walks the sixteen keys one per cycle through the shared
// compare unit, then updates the idle timer and loads the result register in
// its finish step. s_axis_tready is high only while the sequencer is idle, so
// a new scan is taken only after the last one has reached the finish step and
// been committed. A finished result waits in the output register, and the next
// scan is accepted meanwhile; if the receiver still stalls when that scan is
// done, the sequencer holds in its last step until the register frees.
// Reset (synchronous, active low) clears the previous mask, the open entry, the
// timer and the LED, and loads pin_length 4, pin_code 0x3210 and a ten-second
// timeout.
module keypad_pin_entry_lock import kpl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pressed_mask
    input  logic        s_axis_tuser,   // [0] second_tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] led_color, [6:2] pins_accepted, [11:7] pins_rejected,
    // [12] timed_out, [15:13] keys_entered
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]  r_pin_length;
    logic [31:0] r_pin_code;
    logic [7:0]  r_timeout;
    t_reg_idx    reg_idx;
    logic        cfg_wr;
    logic [3:0]  len;
    t_entry_cmd  cmd;
    logic        match;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_length <= 4'd4;
            r_pin_code   <= 32'h0000_3210;
            r_timeout    <= 8'd10;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PIN_LENGTH: r_pin_length <= pwdata[3:0];
                REG_PIN_CODE:   r_pin_code   <= pwdata;
                REG_TIMEOUT:    r_timeout    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_PIN_LENGTH: prdata = {28'd0, r_pin_length};
            REG_PIN_CODE:   prdata = r_pin_code;
            REG_TIMEOUT:    prdata = {24'd0, r_timeout};
            default:        prdata = '0;
        endcase
    end

    assign len = eff_len(r_pin_length);

    kpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mask      (s_axis_tdata),
        .i_tick      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_len       (len),
        .i_timeout   (r_timeout),
        .o_cmd       (cmd),
        .i_match     (match)
    );

    kpl_entry u_entry (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_pin_code (r_pin_code),
        .i_len      (len),
        .o_match    (match)
    );

endmodule

@@ rtl/kpl_entry.sv @@
module kpl_entry import kpl_pkg::*; (
    input  logic        i_clk,
    input  t_entry_cmd  i_cmd,
    input  logic [31:0] i_pin_code,
    input  logic [3:0]  i_len,
    output logic        o_match
);

    logic [3:0] r_keys [SLOTS];

    // key store, one slot written per new press
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_keys[i_cmd.slot] <= i_cmd.key;
        end
    end

    // compare unit: the key being written now stands in for its slot
    always_comb begin
        logic [3:0] key_i;
        o_match = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            key_i = (i_cmd.slot == 3'(i)) ? i_cmd.key : r_keys[i];
            if ((4'(i) < i_len) && (key_i != i_pin_code[4*i +: 4])) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

@@ rtl/kpl_ctrl.sv @@
module kpl_ctrl import kpl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_mask,
    input  logic        i_tick,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_data,
    input  logic [3:0]  i_len,
    input  logic [7:0]  i_timeout,
    output t_entry_cmd  o_cmd,
    input  logic        i_match
);

    t_state      r_state, n_state;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_mask, n_mask;
    logic        r_tick, n_tick;
    logic [15:0] r_prev, n_prev;
    logic [2:0]  r_count, n_count;
    logic        r_timer, n_timer;
    logic [7:0]  r_idle, n_idle;
    t_led        r_led, n_led;
    logic [4:0]  r_acc, n_acc;
    logic [4:0]  r_rej, n_rej;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_data, n_out_data;

    logic        now_bit;
    logic        before_bit;
    logic [3:0]  cnt1;
    logic [7:0]  idle_adv;
    logic        expire;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_prev      <= '0;
            r_count     <= '0;
            r_timer     <= 1'b0;
            r_idle      <= '0;
            r_led       <= LED_OFF;
            r_acc       <= '0;
            r_rej       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_timer     <= n_timer;
            r_idle      <= n_idle;
            r_led       <= n_led;
            r_acc       <= n_acc;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    // captured scan and result payload
    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_tick     <= n_tick;
        r_out_data <= n_out_data;
    end

    assign now_bit    = r_mask[r_idx];
    assign before_bit = r_prev[r_idx];
    assign cnt1       = {1'b0, r_count} + 4'd1;
    assign idle_adv   = (r_tick && (r_idle != 8'hff)) ? r_idle + 8'd1 : r_idle;
    assign expire     = r_timer && (idle_adv >= i_timeout);

    // sequencer: one key per cycle, then timer and result
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_tick      = r_tick;
        n_prev      = r_prev;
        n_count     = r_count;
        n_timer     = r_timer;
        n_idle      = r_idle;
        n_led       = r_led;
        n_acc       = r_acc;
        n_rej       = r_rej;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.wr_en = 1'b0;
        o_cmd.slot  = r_count;
        o_cmd.key   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mask  = i_mask;
                    n_tick  = i_tick;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_rej   = '0;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (key_in_grid(r_idx) && now_bit && !before_bit) begin
                    // new press: append, and close the entry once it reaches the pin length
                    n_prev[r_idx] = 1'b1;
                    o_cmd.wr_en   = 1'b1;
                    n_led         = LED_OFF;
                    n_timer       = 1'b1;
                    n_idle        = '0;
                    if (cnt1 >= i_len) begin
                        if (i_match) begin
                            n_led = LED_GREEN;
                            n_acc = r_acc + 5'd1;
                        end else begin
                            n_led = LED_RED;
                            n_rej = r_rej + 5'd1;
                        end
                        n_count = '0;
                        n_timer = 1'b0;
                    end else begin
                        n_count = cnt1[2:0];
                    end
                end else if (key_in_grid(r_idx) && !now_bit && before_bit) begin
                    n_prev[r_idx] = 1'b0;
                end
                if (r_idx == 4'(NUM_KEYS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_FINISH: begin
                // commit only once the result register is free
                if (!r_out_valid || i_out_ready) begin
                    if (r_timer) begin
                        n_idle = idle_adv;
                    end
                    if (expire) begin
                        n_led   = LED_YELLOW;
                        n_count = '0;
                        n_timer = 1'b0;
                        n_idle  = '0;
                    end
                    n_out_data  = {n_count, expire, r_rej, r_acc, n_led};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/kpl_checker.sv @@
module kpl_checker import kpl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one scan at a time: ready drops after a transaction
    a_one_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second scan taken while busy");

    // a timeout leaves no open entry
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[15:13] == 3'd0)
        else $error("keys left after timeout");

    // a timeout always shows yellow; yellow may linger on later scans
    a_yellow_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[1:0] == LED_YELLOW)
        else $error("timeout without yellow led");

endmodule

bind keypad_pin_entry_lock kpl_checker u_kpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
